FILE: rtl/record_stream_deframer_crc32_defines.svh
// Assertion macros for the record deframer.
`ifndef RECORD_STREAM_DEFRAMER_CRC32_DEFINES_SVH
`define RECORD_STREAM_DEFRAMER_CRC32_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define RSDC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define RSDC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/rsdc_pkg.sv
// Types, codes and the bytewise CRC-32 for the record deframer.
`timescale 1ns / 1ps

package rsdc_pkg;

	localparam logic [31:0] REC_MAGIC      = 32'h5952_4C54;
	localparam logic [15:0] REC_VERSION    = 16'h0001;
	localparam logic [31:0] MAX_SIZE_RESET = 32'd65536;
	localparam logic [31:0] CRC_POLY       = 32'hEDB8_8320;
	localparam logic [31:0] CRC_INIT       = 32'hFFFF_FFFF;
	localparam logic [31:0] CRC_TRAILER    = 32'd4;

	typedef enum logic [2:0] {
		PH_HEADER  = 3'd0,
		PH_SIZE    = 3'd1,
		PH_PAYLOAD = 3'd2,
		PH_CRC     = 3'd3,
		PH_DONE    = 3'd4
	} phase_t;

	typedef enum logic [2:0] {
		KIND_HEADER  = 3'd0,
		KIND_BYTE    = 3'd1,
		KIND_REC_END = 3'd2,
		KIND_CLEAN   = 3'd3,
		KIND_ERROR   = 3'd4
	} kind_t;

	typedef enum logic [3:0] {
		ST_OK          = 4'd0,
		ST_TRUNC_HDR   = 4'd1,
		ST_BAD_MAGIC   = 4'd2,
		ST_BAD_VERSION = 4'd3,
		ST_SIZE_ZERO   = 4'd4,
		ST_TOO_LARGE   = 4'd5,
		ST_TOO_SMALL   = 4'd6,
		ST_TRUNC_REC   = 4'd7,
		ST_CRC_BAD     = 4'd8
	} status_t;

	typedef struct packed {
		logic       op;
		logic [7:0] data_byte;
	} in_beat_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  payload_byte;
		logic [15:0] header_flags;
		logic [31:0] payload_length;
		status_t     status;
	} out_beat_t;

	// Reflected CRC-32, one byte: eight shift-and-xor steps.
	function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

FILE: rtl/record_stream_deframer_crc32.sv
// Length-prefixed record deframer with per-record CRC-32 check.
// A result reaches out_data in the cycle after its input beat is taken.
// Throughput: one input beat per cycle unless the output stalls; per-byte work (CRC
//   byte step, field assembly, size checks) sits between state and result registers.
// Reset (arst_n low, asynchronous): header phase, counters and fields cleared,
//   CRC all ones, max_record_size back to 65536, result register empty.
`timescale 1ns / 1ps
`include "record_stream_deframer_crc32_defines.svh"

module record_stream_deframer_crc32
	import rsdc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// item channel
	input  logic        in_valid,
	output logic        in_ready,
	input  in_beat_t    in_data,
	// result channel
	output logic        out_valid,
	input  logic        out_ready,
	output out_beat_t   out_data,
	// max_record_size write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data
);

	// Stream state. Halted is folded into the done phase.
	phase_t      phase_q;
	logic [2:0]  byte_count_q;
	logic [31:0] field_shift_q;
	logic [15:0] flags_word_q;
	logic [31:0] bytes_left_q;
	logic [31:0] rec_size_q;
	logic [31:0] crc_q;
	logic [31:0] max_size_q;

	// Result register
	logic        out_valid_q;
	out_beat_t   out_data_q;

	// Next values
	phase_t      phase_nxt;
	logic [2:0]  byte_count_nxt;
	logic [31:0] field_shift_nxt;
	logic [15:0] flags_word_nxt;
	logic [31:0] bytes_left_nxt;
	logic [31:0] rec_size_nxt;
	logic [31:0] crc_nxt;
	logic        res_valid;
	out_beat_t   res;

	logic        take;
	logic        is_end;
	logic [31:0] shifted;
	logic        field_last;
	logic        magic_bad;
	logic        ver_bad;
	logic        size_zero;
	logic        size_big;
	logic        size_small;
	logic        size_empty;
	logic        crc_bad;
	logic        pay_last;
	logic [31:0] size_less_crc;

	// The result register frees up when empty or when its beat leaves this cycle,
	// so a new item is taken while a finished result is handed off.
	assign in_ready  = !out_valid_q || out_ready;
	assign take      = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	assign is_end = in_data.op;

	// Drop the byte into its lane of the little-endian field being assembled.
	assign shifted = field_shift_q |
		({24'd0, in_data.data_byte} << {byte_count_q[1:0], 3'b000});

	assign field_last    = (byte_count_q[1:0] == 2'd3);
	assign magic_bad     = (shifted != REC_MAGIC);
	assign ver_bad       = (shifted[15:0] != REC_VERSION);
	assign size_zero     = (shifted == 32'd0);
	assign size_big      = (shifted > max_size_q);
	assign size_small    = (shifted[31:2] == 30'd0);
	assign size_empty    = (shifted == CRC_TRAILER);
	assign size_less_crc = shifted - CRC_TRAILER;
	assign crc_bad       = ((crc_q ^ CRC_INIT) != shifted);
	assign pay_last      = (bytes_left_q == 32'd1);

	// Phase sequencing
	always_comb begin
		phase_nxt = phase_q;
		unique case (phase_q)
			PH_HEADER: begin
				if (is_end) begin
					phase_nxt = PH_DONE;
				end else if (byte_count_q == 3'd3 && magic_bad) begin
					phase_nxt = PH_DONE;
				end else if (byte_count_q == 3'd7) begin
					phase_nxt = ver_bad ? PH_DONE : PH_SIZE;
				end
			end
			PH_SIZE: begin
				if (is_end) begin
					phase_nxt = PH_DONE;
				end else if (field_last) begin
					if (size_zero || size_big || size_small) begin
						phase_nxt = PH_DONE;
					end else begin
						phase_nxt = size_empty ? PH_CRC : PH_PAYLOAD;
					end
				end
			end
			PH_PAYLOAD: begin
				if (is_end) begin
					phase_nxt = PH_DONE;
				end else if (pay_last) begin
					phase_nxt = PH_CRC;
				end
			end
			PH_CRC: begin
				if (is_end) begin
					phase_nxt = PH_DONE;
				end else if (field_last) begin
					phase_nxt = crc_bad ? PH_DONE : PH_SIZE;
				end
			end
			default: begin
				phase_nxt = PH_DONE;
			end
		endcase
	end

	// Datapath updates and the result of this beat
	always_comb begin
		byte_count_nxt  = byte_count_q;
		field_shift_nxt = field_shift_q;
		flags_word_nxt  = flags_word_q;
		bytes_left_nxt  = bytes_left_q;
		rec_size_nxt    = rec_size_q;
		crc_nxt         = crc_q;
		res_valid       = 1'b0;
		res             = '0;
		res.kind        = KIND_ERROR;
		res.status      = ST_OK;

		unique case (phase_q)
			PH_HEADER: begin
				if (is_end) begin
					res_valid  = 1'b1;
					res.status = ST_TRUNC_HDR;
				end else begin
					field_shift_nxt = shifted;
					if (byte_count_q == 3'd3) begin
						if (magic_bad) begin
							res_valid  = 1'b1;
							res.status = ST_BAD_MAGIC;
						end else begin
							field_shift_nxt = '0;
							byte_count_nxt  = byte_count_q + 3'd1;
						end
					end else if (byte_count_q == 3'd7) begin
						// flags are latched even when the version fails
						flags_word_nxt = shifted[31:16];
						byte_count_nxt = 3'd0;
						res_valid      = 1'b1;
						if (ver_bad) begin
							res.status = ST_BAD_VERSION;
						end else begin
							field_shift_nxt  = '0;
							res.kind         = KIND_HEADER;
							res.header_flags = shifted[31:16];
						end
					end else begin
						byte_count_nxt = byte_count_q + 3'd1;
					end
				end
			end
			PH_SIZE: begin
				if (is_end) begin
					res_valid = 1'b1;
					if (byte_count_q == 3'd0) begin
						res.kind = KIND_CLEAN;
					end else begin
						res.status = ST_TRUNC_REC;
					end
				end else if (!field_last) begin
					field_shift_nxt = shifted;
					byte_count_nxt  = byte_count_q + 3'd1;
				end else begin
					field_shift_nxt = '0;
					byte_count_nxt  = 3'd0;
					// check order: zero, then too large, then too small
					if (size_zero) begin
						res_valid  = 1'b1;
						res.status = ST_SIZE_ZERO;
					end else if (size_big) begin
						res_valid  = 1'b1;
						res.status = ST_TOO_LARGE;
					end else if (size_small) begin
						res_valid  = 1'b1;
						res.status = ST_TOO_SMALL;
					end else begin
						rec_size_nxt   = size_less_crc;
						bytes_left_nxt = size_less_crc;
						crc_nxt        = CRC_INIT;
					end
				end
			end
			PH_PAYLOAD: begin
				res_valid = 1'b1;
				if (is_end) begin
					res.status = ST_TRUNC_REC;
				end else begin
					crc_nxt          = crc32_byte(crc_q, in_data.data_byte);
					bytes_left_nxt   = bytes_left_q - 32'd1;
					res.kind         = KIND_BYTE;
					res.payload_byte = in_data.data_byte;
					if (pay_last) begin
						byte_count_nxt  = 3'd0;
						field_shift_nxt = '0;
					end
				end
			end
			PH_CRC: begin
				if (is_end) begin
					res_valid  = 1'b1;
					res.status = ST_TRUNC_REC;
				end else if (!field_last) begin
					field_shift_nxt = shifted;
					byte_count_nxt  = byte_count_q + 3'd1;
				end else begin
					field_shift_nxt = '0;
					byte_count_nxt  = 3'd0;
					res_valid       = 1'b1;
					if (crc_bad) begin
						res.status = ST_CRC_BAD;
					end else begin
						res.kind           = KIND_REC_END;
						res.payload_length = rec_size_q;
					end
				end
			end
			default: begin
				// done: swallow every beat without a result
				res_valid = 1'b0;
			end
		endcase
	end

	// Stream state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_HEADER;
			byte_count_q  <= '0;
			field_shift_q <= '0;
			flags_word_q  <= '0;
			bytes_left_q  <= '0;
			rec_size_q    <= '0;
			crc_q         <= CRC_INIT;
			max_size_q    <= MAX_SIZE_RESET;
		end else begin
			if (cfg_valid && cfg_ready) begin
				max_size_q <= cfg_data;
			end
			if (take) begin
				phase_q       <= phase_nxt;
				byte_count_q  <= byte_count_nxt;
				field_shift_q <= field_shift_nxt;
				flags_word_q  <= flags_word_nxt;
				bytes_left_q  <= bytes_left_nxt;
				rec_size_q    <= rec_size_nxt;
				crc_q         <= crc_nxt;
			end
		end
	end

	// Result register: load on a producing beat, empty once the beat is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= res_valid;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && res_valid) begin
			out_data_q <= res;
		end
	end

	// Checks on the sequencing
	`RSDC_ASSERT_NEXT(a_done_sticky, phase_q == PH_DONE, phase_q == PH_DONE,
		"done phase left before reset")
	`RSDC_ASSERT_NOW(a_final_is_done,
		out_valid_q && (out_data_q.kind == KIND_ERROR || out_data_q.kind == KIND_CLEAN),
		phase_q == PH_DONE, "error or clean end shown while stream still active")
	`RSDC_ASSERT_NOW(a_payload_nonempty, phase_q == PH_PAYLOAD, bytes_left_q != 32'd0,
		"payload phase with no bytes left")
	`RSDC_ASSERT_NOW(a_field_count, phase_q == PH_SIZE || phase_q == PH_CRC,
		byte_count_q[2] == 1'b0, "field byte count past four")

	// flags word is kept for status visibility; hold it stable once the header passes
	`RSDC_ASSERT_NEXT(a_flags_hold, phase_q == PH_PAYLOAD,
		flags_word_q == $past(flags_word_q), "flags word changed after header")

endmodule

FILE: test/deframer_check.sv
// Checker for the record deframer: predicts every result beat and compares it.
`timescale 1ns / 1ps

module deframer_check
	import rsdc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  in_beat_t    in_data,
	input  logic        out_valid,
	input  logic        out_ready,
	input  out_beat_t   out_data,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [31:0] cfg_data,
	output int          outstanding,
	output int          mismatch_count
);

	phase_t      ph;
	logic [2:0]  cnt;
	logic [31:0] shift_word;
	logic [31:0] bytes_left;
	logic [31:0] rec_len;
	logic [31:0] crc_acc;
	logic [31:0] size_limit;
	logic [15:0] flags_word;
	logic        halted;
	out_beat_t   awaited_beats[$];
	out_beat_t   want;
	out_beat_t   predicted;

	function automatic logic [31:0] crc32_update(input logic [31:0] c, input logic [7:0] b);
		logic [31:0] r;
		r = c ^ {24'h0, b};
		for (int k = 0; k < 8; k++) begin
			if (r[0])
				r = (r >> 1) ^ CRC_POLY;
			else
				r = r >> 1;
		end
		return r;
	endfunction

	function automatic bit raise_error(input status_t st, output out_beat_t res);
		halted = 1'b1;
		ph = PH_DONE;
		res = '0;
		res.kind = KIND_ERROR;
		res.status = st;
		return 1'b1;
	endfunction

	// Advance the deframer by one input beat; return 1 when it yields a result.
	function automatic bit deframe_step(input in_beat_t beat, output out_beat_t res);
		logic [1:0]  pos;
		logic [31:0] word;
		res = '0;
		if (halted || ph > PH_CRC)
			return 1'b0;
		if (beat.op) begin
			if (ph == PH_HEADER)
				return raise_error(ST_TRUNC_HDR, res);
			if (ph == PH_SIZE && cnt == 3'd0) begin
				halted = 1'b1;
				ph = PH_DONE;
				res.kind = KIND_CLEAN;
				return 1'b1;
			end
			return raise_error(ST_TRUNC_REC, res);
		end
		pos = cnt[1:0];
		case (ph)
			PH_HEADER: begin
				shift_word = shift_word | ({24'h0, beat.data_byte} << (8 * pos));
				if (cnt == 3'd3) begin
					if (shift_word != REC_MAGIC)
						return raise_error(ST_BAD_MAGIC, res);
					shift_word = '0;
				end else if (cnt >= 3'd7) begin
					flags_word = shift_word[31:16];
					cnt = 3'd0;
					if (shift_word[15:0] != REC_VERSION)
						return raise_error(ST_BAD_VERSION, res);
					shift_word = '0;
					ph = PH_SIZE;
					res.kind = KIND_HEADER;
					res.header_flags = flags_word;
					return 1'b1;
				end
				cnt = cnt + 3'd1;
				return 1'b0;
			end
			PH_SIZE, PH_CRC: begin
				shift_word = shift_word | ({24'h0, beat.data_byte} << (8 * pos));
				if (pos < 2'd3) begin
					cnt = {1'b0, pos} + 3'd1;
					return 1'b0;
				end
				cnt = 3'd0;
				word = shift_word;
				shift_word = '0;
				if (ph == PH_CRC) begin
					if (~crc_acc != word)
						return raise_error(ST_CRC_BAD, res);
					ph = PH_SIZE;
					res.kind = KIND_REC_END;
					res.payload_length = rec_len;
					return 1'b1;
				end
				if (word == 32'd0)
					return raise_error(ST_SIZE_ZERO, res);
				if (word > size_limit)
					return raise_error(ST_TOO_LARGE, res);
				if (word < CRC_TRAILER)
					return raise_error(ST_TOO_SMALL, res);
				rec_len = word - CRC_TRAILER;
				bytes_left = rec_len;
				crc_acc = CRC_INIT;
				ph = (bytes_left != 0) ? PH_PAYLOAD : PH_CRC;
				return 1'b0;
			end
			default: begin
				crc_acc = crc32_update(crc_acc, beat.data_byte);
				bytes_left = bytes_left - 32'd1;
				if (bytes_left == 0) begin
					ph = PH_CRC;
					cnt = 3'd0;
					shift_word = '0;
				end
				res.kind = KIND_BYTE;
				res.payload_byte = beat.data_byte;
				return 1'b1;
			end
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph = PH_HEADER;
			cnt = '0;
			shift_word = '0;
			bytes_left = '0;
			rec_len = '0;
			crc_acc = CRC_INIT;
			size_limit = MAX_SIZE_RESET;
			flags_word = '0;
			halted = 1'b0;
			awaited_beats.delete();
			mismatch_count = 0;
			outstanding <= 0;
		end else begin
			// A result always trails its input beat, so compare before predicting.
			if (out_valid && out_ready) begin
				if (awaited_beats.size() == 0) begin
					if (mismatch_count < 10)
						$display("%0t: result beat with none expected: kind %0d byte %02h flags %04h len %0d status %0d",
							$time, out_data.kind, out_data.payload_byte, out_data.header_flags,
							out_data.payload_length, out_data.status);
					mismatch_count++;
				end else begin
					want = awaited_beats.pop_front();
					if (out_data.kind !== want.kind || out_data.payload_byte !== want.payload_byte ||
						out_data.header_flags !== want.header_flags ||
						out_data.payload_length !== want.payload_length ||
						out_data.status !== want.status) begin
						if (mismatch_count < 10) begin
							$display("%0t: expected kind %0d byte %02h flags %04h len %0d status %0d",
								$time, want.kind, want.payload_byte, want.header_flags,
								want.payload_length, want.status);
							$display("%0t: actual   kind %0d byte %02h flags %04h len %0d status %0d",
								$time, out_data.kind, out_data.payload_byte, out_data.header_flags,
								out_data.payload_length, out_data.status);
						end
						mismatch_count++;
					end
				end
			end
			if (cfg_valid && cfg_ready)
				size_limit = cfg_data;
			if (in_valid && in_ready) begin
				if (deframe_step(in_data, predicted))
					awaited_beats.push_back(predicted);
			end
			outstanding <= awaited_beats.size();
		end
	end

endmodule

FILE: test/tb_top.sv
// Testbench top for the record deframer: drives streams and gives the verdict.
`timescale 1ns / 1ps

module tb_top;
	import rsdc_pkg::*;

	// How the stream ends. Reset comes only once, so each run reaches one
	// terminal event; the seed picks which.
	typedef enum int {
		END_CLEAN,
		END_TRUNC_SIZE,
		END_TRUNC_PAYLOAD,
		END_TRUNC_CRC,
		END_SIZE_ZERO,
		END_TOO_LARGE,
		END_TOO_SMALL,
		END_CRC_BAD,
		HDR_TRUNC,
		HDR_BAD_MAGIC,
		HDR_BAD_VERSION
	} ending_t;

	typedef enum int {
		FILL_RANDOM,
		FILL_ZEROS,
		FILL_ONES
	} fill_t;

	typedef enum int {
		PACE_FREE,
		PACE_SENDER_IDLE,
		PACE_RECEIVER_STALL,
		PACE_BOTH
	} pace_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	in_beat_t    in_data = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	out_beat_t   out_data;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [31:0] cfg_data = '0;
	int          outstanding;
	int          mismatch_count;
	int          send_idle_pct = 0;
	int          stall_pct = 0;
	int          beats_sent = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	record_stream_deframer_crc32 u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	deframer_check u_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.in_data        (in_data),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_data       (out_data),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.outstanding    (outstanding),
		.mismatch_count (mismatch_count)
	);

	// Receiver: stall at random, redrawn every cycle.
	always @(posedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	// Offer one beat after a random idle gap, hold it until taken, and leave
	// valid high so the next beat can follow back to back.
	task automatic put_beat(input logic is_end, input logic [7:0] value);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= {is_end, value};
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		beats_sent++;
	endtask

	// Send a 32-bit field, low byte first.
	task automatic send_word(input logic [31:0] w);
		for (int i = 0; i < 4; i++)
			put_beat(1'b0, w[8*i +: 8]);
	endtask

	// Drop valid and hold until every expected result is out, then keep waiting
	// for beats that yield nothing.
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Write max_record_size only while the block is idle.
	task automatic write_limit(input logic [31:0] v);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_pace(input pace_t p);
		case (p)
			PACE_FREE: begin
				send_idle_pct = 0;
				stall_pct = 0;
			end
			PACE_SENDER_IDLE: begin
				send_idle_pct = 84;
				stall_pct = 0;
			end
			PACE_RECEIVER_STALL: begin
				send_idle_pct = 0;
				stall_pct = 84;
			end
			default: begin
				send_idle_pct = 21;
				stall_pct = 21;
			end
		endcase
	endtask

	// One whole record: size field, payload, stored CRC. Corrupt flips one
	// bit of the stored CRC.
	task automatic send_record(input int unsigned n, input fill_t fill, input bit corrupt);
		logic [31:0] crc;
		logic [31:0] stored;
		logic [7:0]  b;
		crc = CRC_INIT;
		send_word(n + CRC_TRAILER);
		for (int i = 0; i < n; i++) begin
			case (fill)
				FILL_ZEROS: b = 8'h00;
				FILL_ONES:  b = 8'hFF;
				default:    b = 8'($urandom_range(0, 255));
			endcase
			crc = crc32_byte(crc, b);
			put_beat(1'b0, b);
		end
		stored = ~crc;
		if (corrupt)
			stored = stored ^ (32'd1 << $urandom_range(0, 31));
		send_word(stored);
	endtask

	// Random beats, end markers among them; after a halt none may yield a result.
	task automatic send_noise(input int count);
		for (int i = 0; i < count; i++)
			put_beat(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
	endtask

	initial begin
		ending_t     ending;
		logic [15:0] flags;
		logic [15:0] version;
		logic [31:0] word;
		logic [63:0] header;
		int unsigned n;
		int unsigned k;
		int unsigned rec_no;
		fill_t       fill;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Lowest limit first; it is overwritten before any record is seen.
		write_limit(32'd0);

		// Mostly a good header and a long record stream; now and then a broken header.
		if ($urandom_range(0, 9) == 0)
			ending = ending_t'($urandom_range(HDR_TRUNC, HDR_BAD_VERSION));
		else
			ending = ending_t'($urandom_range(END_CLEAN, END_CRC_BAD));

		case ($urandom_range(0, 2))
			0:       flags = 16'h0000;
			1:       flags = 16'hFFFF;
			default: flags = 16'($urandom_range(0, 65535));
		endcase
		header = {flags, REC_VERSION, REC_MAGIC};

		if (ending >= HDR_TRUNC) begin
			case (ending)
				HDR_TRUNC: begin
					// End can come before any byte at all.
					k = $urandom_range(0, 7);
					for (int i = 0; i < k; i++)
						put_beat(1'b0, header[8*i +: 8]);
					put_beat(1'b1, 8'($urandom_range(0, 255)));
				end
				HDR_BAD_MAGIC: begin
					k = $urandom_range(0, 3);
					word = REC_MAGIC ^ (32'($urandom_range(1, 255)) << (8 * k));
					send_word(word);
				end
				default: begin
					// Flags still get read before the version check fires.
					version = 16'($urandom_range(0, 65535));
					if (version == REC_VERSION)
						version = 16'hFFFF;
					send_word(REC_MAGIC);
					send_word({flags, version});
				end
			endcase
			send_noise(40);
		end else begin
			// Directed part: empty payload, then a record whose size equals the limit.
			write_limit(32'd5);
			send_word(header[31:0]);
			send_word(header[63:32]);
			send_record(0, FILL_RANDOM, 1'b0);
			send_record(1, FILL_ONES, 1'b0);
			write_limit(32'hFFFF_FFFF);

			// Random part: well-formed records with random content, pacing
			// rotated every few records, limit rewritten now and then.
			rec_no = 0;
			while (beats_sent < 650) begin
				if (rec_no % 6 == 0)
					set_pace(pace_t'((rec_no / 6) % 4));
				if (rec_no % 15 == 14) begin
					case ($urandom_range(0, 3))
						0:       write_limit(32'hFFFF_FFFF);
						1:       write_limit(MAX_SIZE_RESET);
						2:       write_limit(32'd104);
						default: write_limit($urandom_range(104, 32'h7FFF_FFFF));
					endcase
				end
				if ($urandom_range(0, 19) == 0)
					n = $urandom_range(13, 100);
				else
					n = $urandom_range(0, 12);
				if ($urandom_range(0, 7) == 0)
					fill = fill_t'($urandom_range(FILL_ZEROS, FILL_ONES));
				else
					fill = FILL_RANDOM;
				send_record(n, fill, 1'b0);
				rec_no++;
			end

			// Terminal event for this run.
			case (ending)
				END_CLEAN:
					put_beat(1'b1, 8'($urandom_range(0, 255)));
				END_TRUNC_SIZE: begin
					k = $urandom_range(1, 3);
					for (int i = 0; i < k; i++)
						put_beat(1'b0, 8'($urandom_range(0, 255)));
					put_beat(1'b1, 8'($urandom_range(0, 255)));
				end
				END_TRUNC_PAYLOAD: begin
					n = $urandom_range(1, 12);
					send_word(n + CRC_TRAILER);
					k = $urandom_range(0, n - 1);
					for (int i = 0; i < k; i++)
						put_beat(1'b0, 8'($urandom_range(0, 255)));
					put_beat(1'b1, 8'($urandom_range(0, 255)));
				end
				END_TRUNC_CRC: begin
					n = $urandom_range(0, 12);
					send_word(n + CRC_TRAILER);
					k = n + $urandom_range(0, 3);
					for (int i = 0; i < k; i++)
						put_beat(1'b0, 8'($urandom_range(0, 255)));
					put_beat(1'b1, 8'($urandom_range(0, 255)));
				end
				END_SIZE_ZERO:
					send_word(32'd0);
				END_TOO_LARGE: begin
					// A tight limit also checks that too large wins over too small.
					case ($urandom_range(0, 3))
						0:       word = 32'd0;
						1:       word = 32'd3;
						2:       word = $urandom_range(4, 100);
						default: word = 32'hFFFF_FFFE;
					endcase
					write_limit(word);
					if (word == 32'hFFFF_FFFE)
						send_word(32'hFFFF_FFFF);
					else
						send_word(word + 32'd1 + $urandom_range(0, 3));
				end
				END_TOO_SMALL:
					send_word($urandom_range(1, 3));
				default:
					send_record($urandom_range(0, 12), FILL_RANDOM, 1'b1);
			endcase
			send_noise(30);
		end

		wait_idle();
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin
		#2_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule

FILE: files.f
+incdir+rtl
rtl/rsdc_pkg.sv
rtl/record_stream_deframer_crc32.sv
test/deframer_check.sv
test/tb_top.sv
